[hw/rtl/frc_pkg.sv]
`timescale 1ns / 1ps
package frc_pkg;
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int TOT_BITS   = 32;

  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_GET    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_EXISTS = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, clear scan
    logic scan;       // examine slot at scan index
    logic decide;     // resolve hit/evict/insert
    logic shift;      // rank shift after a drop, one slot per cycle
    logic commit;     // write slot, counters
    logic emit;       // drive result strobe
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic shift_last;
    logic need_shift;
  } stat_t;
endpackage

[hw/rtl/fifo_replacement_cache.sv]
`timescale 1ns / 1ps
// FIFO-replacement key/value cache, 16 slots, fully associative. Raise start
// with a beat (mode/key/value) while busy is low; exactly one result beat
// follows, shown for one cycle with out_strobe high. The receiver cannot stall,
// so sample on out_strobe. After the accepting edge, busy stays high through a
// sequential key/age scan of the slot array, a decide step, a commit step and an
// output step; the result beat shows in the cycle after the output step, when
// busy is already low. A put that evicts or a remove hit adds a rank-shift pass
// after the decide step. Capacity must be written on the cfg channel only while
// idle; the block itself does not enforce this.
module fifo_replacement_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_lookup_key,
  input  logic [31:0] in_write_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_capacity_limit,
  output logic        out_strobe,
  output logic        out_found,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_entry_count,
  output logic        out_evicted,
  output logic [31:0] out_request_total,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_eviction_total
);
  import frc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [4:0] cap_r;

  assign cfg_ready = 1'b1;

  // capacity register; reset to full size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity_limit;
    end
  end

  frc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  frc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_mode            (in_mode),
    .in_lookup_key      (in_lookup_key),
    .in_write_value     (in_write_value),
    .cap_limit          (cap_r),
    .out_strobe         (out_strobe),
    .out_found          (out_found),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count),
    .out_evicted        (out_evicted),
    .out_request_total  (out_request_total),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );
endmodule

[hw/rtl/frc_ctrl.sv]
`timescale 1ns / 1ps
module frc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  frc_pkg::stat_t stat,
  output frc_pkg::ctrl_t ctrl
);
  import frc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.scan_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        ctrl.decide = 1'b1;
        state_nxt = stat.need_shift ? ST_SHIFT : ST_COMMIT;
      end
      ST_SHIFT: begin
        ctrl.shift = 1'b1;
        if (stat.shift_last) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctrl.commit = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        ctrl.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[hw/rtl/frc_dp.sv]
`timescale 1ns / 1ps
module frc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  frc_pkg::ctrl_t                 ctrl,
  output frc_pkg::stat_t                 stat,
  input  logic [2:0]                     in_mode,
  input  logic [frc_pkg::KEY_BITS-1:0]   in_lookup_key,
  input  logic [frc_pkg::VALUE_BITS-1:0] in_write_value,
  input  logic [4:0]                     cap_limit,
  output logic                           out_strobe,
  output logic                           out_found,
  output logic [31:0]                    out_read_value,
  output logic [4:0]                     out_entry_count,
  output logic                           out_evicted,
  output logic [31:0]                    out_request_total,
  output logic [31:0]                    out_hit_total,
  output logic [31:0]                    out_miss_total,
  output logic [31:0]                    out_eviction_total
);
  import frc_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [IDX_BITS-1:0]   rank_r  [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [TOT_BITS-1:0]   req_r, hit_r, miss_r, evc_r;

  logic [2:0]            mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;
  logic [IDX_BITS-1:0]   idx_r;
  logic                  hit_r_f;
  logic [IDX_BITS-1:0]   hit_idx_r;
  logic                  old_f_r;
  logic [IDX_BITS-1:0]   old_idx_r;
  logic                  free_f_r;
  logic [IDX_BITS-1:0]   free_idx_r;
  logic [IDX_BITS-1:0]   drop_rank_r;
  logic                  ins_r;
  logic                  evict_r;
  logic                  found_r;
  logic [VALUE_BITS-1:0] rd_r;

  logic [CNT_BITS-1:0]   cap_eff;
  logic                  is_put, do_evict, do_drop;
  logic [IDX_BITS-1:0]   drop_idx;
  logic [CNT_BITS-1:0]   count_drop;

  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ENTRIES - 1);

  always_comb begin
    if (cap_limit == '0) cap_eff = CNT_BITS'(1);
    else if (cap_limit > 5'(ENTRIES)) cap_eff = CNT_BITS'(ENTRIES);
    else cap_eff = CNT_BITS'(cap_limit);
  end

  assign is_put   = (mode_r == MODE_PUT);
  assign do_evict = is_put && !hit_r_f && (count_r >= cap_eff) && old_f_r;
  assign do_drop  = do_evict || (mode_r == MODE_REMOVE && hit_r_f);
  assign drop_idx = do_evict ? old_idx_r : hit_idx_r;

  assign stat.scan_last  = (idx_r == IDX_LAST);
  assign stat.shift_last = (idx_r == IDX_LAST);
  assign stat.need_shift = do_drop;

  assign count_drop = (count_r != '0) ? count_r - CNT_BITS'(1) : count_r;

  function automatic logic [TOT_BITS-1:0] sat_inc(input logic [TOT_BITS-1:0] c);
    return (&c) ? c : c + TOT_BITS'(1);
  endfunction

  // slot memories: one write port
  always_ff @(posedge clk) begin
    if (ctrl.commit && ins_r) begin
      key_mem[free_idx_r] <= key_r;
      val_mem[free_idx_r] <= wval_r;
    end else if (ctrl.commit && is_put && hit_r_f) begin
      val_mem[hit_idx_r] <= wval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      req_r   <= '0;
      hit_r   <= '0;
      miss_r  <= '0;
      evc_r   <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctrl.emit;
      if (ctrl.decide && do_drop) begin
        valid_r[drop_idx] <= 1'b0;
        count_r <= count_drop;
      end
      if (ctrl.commit) begin
        if (mode_r == MODE_CLEAR) begin
          valid_r <= '0;
          count_r <= '0;
        end
        if (ins_r) begin
          valid_r[free_idx_r] <= 1'b1;
          count_r <= count_r + CNT_BITS'(1);
        end
        if (evict_r) evc_r <= sat_inc(evc_r);
        if (mode_r == MODE_GET) begin
          req_r <= sat_inc(req_r);
          if (hit_r_f) hit_r <= sat_inc(hit_r);
          else miss_r <= sat_inc(miss_r);
        end
      end
    end
  end

  // rank updates: shift younger ranks one at a time, set new rank on insert
  always_ff @(posedge clk) begin
    if (ctrl.shift && valid_r[idx_r] && rank_r[idx_r] > drop_rank_r)
      rank_r[idx_r] <= rank_r[idx_r] - IDX_BITS'(1);
    if (ctrl.commit && ins_r)
      rank_r[free_idx_r] <= count_r[IDX_BITS-1:0];
  end

  // item capture, scan and decisions
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mode_r   <= in_mode;
      key_r    <= in_lookup_key;
      wval_r   <= in_write_value;
      idx_r    <= '0;
      hit_r_f  <= 1'b0;
      old_f_r  <= 1'b0;
      free_f_r <= 1'b0;
      hit_idx_r  <= '0;
      old_idx_r  <= '0;
      free_idx_r <= '0;
    end
    if (ctrl.scan) begin
      idx_r <= idx_r + IDX_BITS'(1);
      if (valid_r[idx_r] && key_mem[idx_r] == key_r && !hit_r_f) begin
        hit_r_f   <= 1'b1;
        hit_idx_r <= idx_r;
      end
      if (valid_r[idx_r] && rank_r[idx_r] == '0 && !old_f_r) begin
        old_f_r   <= 1'b1;
        old_idx_r <= idx_r;
      end
      if (!valid_r[idx_r] && !free_f_r) begin
        free_f_r   <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
    if (ctrl.decide) begin
      idx_r       <= '0;
      evict_r     <= do_evict;
      drop_rank_r <= rank_r[drop_idx];
      found_r     <= hit_r_f && (mode_r == MODE_GET || mode_r == MODE_EXISTS);
      rd_r        <= (hit_r_f && mode_r == MODE_GET) ? val_mem[hit_idx_r] : '0;
      // lowest free slot; an evicted slot below the first free one wins
      ins_r       <= is_put && !hit_r_f && (free_f_r || do_evict);
      if (do_evict && (!free_f_r || old_idx_r < free_idx_r))
        free_idx_r <= old_idx_r;
    end
    if (ctrl.shift) idx_r <= idx_r + IDX_BITS'(1);
  end

  assign out_found          = found_r;
  assign out_read_value     = rd_r;
  assign out_entry_count    = 5'(count_r);
  assign out_evicted        = evict_r;
  assign out_request_total  = req_r;
  assign out_hit_total      = hit_r;
  assign out_miss_total     = miss_r;
  assign out_eviction_total = evc_r;
endmodule

[hw/rtl/frc_checker.sv]
`timescale 1ns / 1ps
module frc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_found,
  input logic [31:0] out_read_value,
  input logic [4:0]  out_entry_count,
  input logic        out_evicted
);
  a_no_strobe_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe) else $error("strobe right after accept");
  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy during result");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_entry_count <= 5'd16) else $error("count overflow");
  a_rd_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> out_read_value == 32'd0) else $error("stray value");
  a_evict_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_evicted) |-> !out_found) else $error("evict with found");
endmodule

bind fifo_replacement_cache frc_checker u_frc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_found(out_found), .out_read_value(out_read_value),
  .out_entry_count(out_entry_count), .out_evicted(out_evicted)
);

[tb/tb_fifo_replacement_cache.sv]
`timescale 1ns / 1ps
module tb_fifo_replacement_cache;
  import frc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [31:0] in_lookup_key = '0;
  logic [31:0] in_write_value = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_capacity_limit = '0;
  logic        out_strobe;
  logic        out_found;
  logic [31:0] out_read_value;
  logic [4:0]  out_entry_count;
  logic        out_evicted;
  logic [31:0] out_request_total;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;
  logic [31:0] out_eviction_total;

  fifo_replacement_cache DUT (.*);

  always #6 clk = ~clk;

  // one expected result beat
  typedef struct {
    logic        found;
    logic [31:0] read_value;
    logic [4:0]  entry_count;
    logic        evicted;
    logic [31:0] requests;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } cache_result_t;

  cache_result_t pending_results[$];
  int error_count = 0;

  // shadow copy of the cache state
  logic [KEY_BITS-1:0]   shadow_key[ENTRIES];
  logic [VALUE_BITS-1:0] shadow_value[ENTRIES];
  logic                  shadow_valid[ENTRIES];
  int unsigned           shadow_rank[ENTRIES];
  int unsigned           shadow_count;
  logic [31:0]           cnt_req, cnt_hit, cnt_miss, cnt_evict;
  logic [4:0]            shadow_capacity;

  // sender burst state
  int burst_left = 0;

  // key pool so that gets/removes/puts actually hit
  logic [31:0] key_pool[24];

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  // drop slot and close the gap in the FIFO order
  function automatic void drop_entry(int s);
    int unsigned r;
    r = shadow_rank[s];
    shadow_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
    if (shadow_count > 0) shadow_count--;
  endfunction

  // apply one operation to the shadow state, return the expected beat
  function automatic cache_result_t apply_op(logic [2:0] m, logic [31:0] k, logic [31:0] v);
    cache_result_t r;
    int unsigned cap;
    int s;
    int oldest;
    r = '{default: '0};
    cap = shadow_capacity;
    if (cap < 1) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    case (m)
      MODE_PUT: begin
        s = find_key(k);
        if (s >= 0) begin
          shadow_value[s] = v;
        end else begin
          if (shadow_count >= cap) begin
            oldest = -1;
            for (int i = ENTRIES - 1; i >= 0; i--)
              if (shadow_valid[i] && shadow_rank[i] == 0) oldest = i;
            if (oldest >= 0) begin
              drop_entry(oldest);
              cnt_evict = sat_inc(cnt_evict);
              r.evicted = 1'b1;
            end
          end
          // lowest free slot takes the newest rank
          for (int i = 0; i < ENTRIES; i++) begin
            if (!shadow_valid[i]) begin
              shadow_valid[i] = 1'b1;
              shadow_key[i]   = k;
              shadow_value[i] = v;
              shadow_rank[i]  = shadow_count;
              shadow_count++;
              break;
            end
          end
        end
      end
      MODE_GET: begin
        cnt_req = sat_inc(cnt_req);
        s = find_key(k);
        if (s >= 0) begin
          cnt_hit = sat_inc(cnt_hit);
          r.found = 1'b1;
          r.read_value = shadow_value[s];
        end else begin
          cnt_miss = sat_inc(cnt_miss);
        end
      end
      MODE_REMOVE: begin
        s = find_key(k);
        if (s >= 0) drop_entry(s);
      end
      MODE_EXISTS: r.found = (find_key(k) >= 0);
      MODE_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
        shadow_count = 0;
      end
      default: ;  // undefined modes leave state alone
    endcase
    r.entry_count = shadow_count[4:0];
    r.requests  = cnt_req;
    r.hits      = cnt_hit;
    r.misses    = cnt_miss;
    r.evictions = cnt_evict;
    return r;
  endfunction

  // send one item; honors the burst/gap pattern of the sender
  task automatic send_op(logic [2:0] m, logic [31:0] k, logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    @(posedge clk);
    start          <= 1'b1;
    in_mode        <= m;
    in_lookup_key  <= k;
    in_write_value <= v;
    do @(posedge clk); while (busy);
    // beat accepted at this edge
    pending_results.push_back(apply_op(m, k, v));
    start <= 1'b0;
  endtask

  // register write, only with the block drained
  task automatic write_capacity(logic [4:0] c);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_capacity_limit <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_capacity = c;
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
  endfunction

  // result checker: strobe beats cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, found=%0b count=%0d", $time,
                 out_found, out_entry_count);
        error_count++;
      end else begin
        cache_result_t e;
        e = pending_results.pop_front();
        if (out_found !== e.found) begin
          $display("%0t: found exp %0b got %0b", $time, e.found, out_found);
          error_count++;
        end
        if (out_read_value !== e.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, e.read_value, out_read_value);
          error_count++;
        end
        if (out_entry_count !== e.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                   out_entry_count);
          error_count++;
        end
        if (out_evicted !== e.evicted) begin
          $display("%0t: evicted exp %0b got %0b", $time, e.evicted, out_evicted);
          error_count++;
        end
        if (out_request_total !== e.requests) begin
          $display("%0t: request_total exp %0d got %0d", $time, e.requests,
                   out_request_total);
          error_count++;
        end
        if (out_hit_total !== e.hits) begin
          $display("%0t: hit_total exp %0d got %0d", $time, e.hits, out_hit_total);
          error_count++;
        end
        if (out_miss_total !== e.misses) begin
          $display("%0t: miss_total exp %0d got %0d", $time, e.misses, out_miss_total);
          error_count++;
        end
        if (out_eviction_total !== e.evictions) begin
          $display("%0t: eviction_total exp %0d got %0d", $time, e.evictions,
                   out_eviction_total);
          error_count++;
        end
      end
    end
  end

  // every mode, key/value extremes, undefined modes, absent remove, clear
  task automatic test_modes_and_extremes();
    send_op(MODE_GET, 32'h0, 32'h0);                    // miss on empty
    send_op(MODE_PUT, 32'h0, 32'hFFFF_FFFF);
    send_op(MODE_PUT, 32'hFFFF_FFFF, 32'h0);
    send_op(MODE_GET, 32'h0, 32'h0);
    send_op(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(MODE_PUT, 32'h0, 32'hA5A5_5A5A);            // update, keeps its age
    send_op(MODE_EXISTS, 32'h0, 32'h0);
    send_op(MODE_EXISTS, 32'h1234_5678, 32'h0);
    send_op(MODE_REMOVE, 32'h1234_5678, 32'h0);         // absent: no change
    send_op(MODE_REMOVE, 32'h0, 32'h0);
    send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(3'd6, 32'h0, 32'h0);
    send_op(3'd7, 32'hFFFF_FFFF, 32'h0);
    send_op(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(MODE_GET, 32'hFFFF_FFFF, 32'h0);
  endtask

  // fill the store, then shrink capacity below the count
  task automatic test_capacity_shrink();
    for (int i = 0; i < ENTRIES + 2; i++) send_op(MODE_PUT, 32'h100 + i, $urandom());
    write_capacity(5'd4);
    send_op(MODE_PUT, 32'hBEEF, 32'h1);                 // one eviction, count stays full
    send_op(MODE_GET, 32'h102, 32'h0);                  // oldest should be gone
    write_capacity(5'd0);                               // acts as one
    send_op(MODE_CLEAR, 32'h0, 32'h0);
    send_op(MODE_PUT, 32'h1, 32'h11);
    send_op(MODE_PUT, 32'h2, 32'h22);
    send_op(MODE_GET, 32'h1, 32'h0);
    write_capacity(5'd31);                              // clamps to 16
    for (int i = 0; i < ENTRIES + 1; i++) send_op(MODE_PUT, 32'h200 + i, $urandom());
  endtask

  // random traffic over several capacity settings
  task automatic test_random_traffic();
    logic [4:0] caps[8] = '{5'd1, 5'd3, 5'd16, 5'd8, 5'd0, 5'd31, 5'd2, 5'd12};
    int r;
    logic [2:0] m;
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      for (int n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) m = MODE_PUT;
        else if (r < 60) m = MODE_GET;
        else if (r < 75) m = MODE_REMOVE;
        else if (r < 90) m = MODE_EXISTS;
        else if (r < 93) m = MODE_CLEAR;
        else m = 3'($urandom_range(0, 7));
        send_op(m, pick_key(), $urandom());
      end
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
    shadow_count = 0;
    cnt_req = '0; cnt_hit = '0; cnt_miss = '0; cnt_evict = '0;
    shadow_capacity = 5'd16;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_modes_and_extremes();
    test_capacity_shrink();
    test_random_traffic();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("** fifo_replacement_cache: PASSED **");
    else
      $display("** fifo_replacement_cache: FAILED **");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("** fifo_replacement_cache: FAILED **");
    $finish;
  end

endmodule
